/* sv/svpwm_pkg.sv */
// Shared types, constants and helpers for the space vector PWM duty core.
package svpwm_pkg;

  localparam int unsigned CmpW  = 16;  // compare value and timer top width
  localparam int unsigned ProjW = 34;  // projections and active times, Q.31
  localparam int unsigned DutyW = 36;  // duties before saturation, Q.32
  localparam int unsigned SatW  = 33;  // saturated duty, 0 .. 2^32

  // sqrt(3)/2 as an unsigned Q.16 fraction.
  localparam logic [16:0] SqrtHalfQ16 = 17'd56756;

  localparam logic [CmpW-1:0] TopReset = 16'd1799;

  // Sign code of the projections: bit 0 is I > 0, bit 1 is J > 0, bit 2 is K > 0.
  localparam logic [2:0] SgnNone = 3'b000;
  localparam logic [2:0] SgnI    = 3'b001;
  localparam logic [2:0] SgnJ    = 3'b010;
  localparam logic [2:0] SgnIJ   = 3'b011;
  localparam logic [2:0] SgnK    = 3'b100;
  localparam logic [2:0] SgnIK   = 3'b101;
  localparam logic [2:0] SgnJK   = 3'b110;
  localparam logic [2:0] SgnAll  = 3'b111;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } in_t;

  typedef struct packed {
    logic [CmpW-1:0] compare_u;
    logic [CmpW-1:0] compare_v;
    logic [CmpW-1:0] compare_w;
    logic [2:0]      sector;
    logic            updated;
  } out_t;

  typedef struct packed {
    logic                    valid;
    logic [2:0]              code;
    logic signed [ProjW-1:0] t1;
    logic signed [ProjW-1:0] t2;
  } times_t;

  typedef struct packed {
    logic            valid;
    logic [2:0]      code;
    logic [SatW-1:0] du;
    logic [SatW-1:0] dv;
    logic [SatW-1:0] dw;
  } duty_t;

  function automatic logic [2:0] sector_of(input logic [2:0] code);
    logic [2:0] sec;
    case (code)
      SgnI:    sec = 3'd6;
      SgnJ:    sec = 3'd2;
      SgnIJ:   sec = 3'd1;
      SgnK:    sec = 3'd4;
      SgnIK:   sec = 3'd5;
      SgnJK:   sec = 3'd3;
      default: sec = 3'd0;
    endcase
    return sec;
  endfunction

  function automatic logic code_ok(input logic [2:0] code);
    return (code != SgnNone) && (code != SgnAll);
  endfunction

endpackage

/* sv/svpwm_proj.sv */
// Projection stages: inverse Clarke projections, sign code and active times.
module svpwm_proj (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  svpwm_pkg::in_t      in_i,
  output svpwm_pkg::times_t   times_o
);

  localparam int unsigned W = svpwm_pkg::ProjW;

  logic                s1_valid_q;
  logic signed [W-1:0] s1_m_q, s1_m_d;
  logic signed [15:0]  s1_b_q;

  logic                s2_valid_q;
  svpwm_pkg::times_t   s2_q, s2_d;

  logic signed [W-1:0] bsh, pi, pj, pk;
  logic [2:0]          code;

  // Stage 1: the one product, alpha * sqrt(3)/2 in Q.31.
  assign s1_m_d = W'(in_i.alpha) * W'($signed({1'b0, svpwm_pkg::SqrtHalfQ16}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_m_q <= s1_m_d;
    s1_b_q <= in_i.beta;
    s2_q   <= s2_d;
  end

  // Stage 2: projections, sign code and the two active times.
  assign bsh = {{3{s1_b_q[15]}}, s1_b_q, 15'b0};
  assign pi  = s1_m_q - bsh;
  assign pj  = {{2{s1_b_q[15]}}, s1_b_q, 16'b0};
  assign pk  = -s1_m_q - bsh;

  assign code = {(pk > 0), (pj > 0), (pi > 0)};

  always_comb begin
    s2_d       = '0;
    s2_d.valid = 1'b1;
    s2_d.code  = code;
    case (code)
      svpwm_pkg::SgnIJ: begin
        s2_d.t1 = pi;
        s2_d.t2 = pj;
      end
      svpwm_pkg::SgnJ: begin
        s2_d.t1 = -pk;
        s2_d.t2 = -pi;
      end
      svpwm_pkg::SgnJK: begin
        s2_d.t1 = pj;
        s2_d.t2 = pk;
      end
      svpwm_pkg::SgnK: begin
        s2_d.t1 = -pi;
        s2_d.t2 = -pj;
      end
      svpwm_pkg::SgnIK: begin
        s2_d.t1 = pk;
        s2_d.t2 = pi;
      end
      svpwm_pkg::SgnI: begin
        s2_d.t1 = -pj;
        s2_d.t2 = -pk;
      end
      default: begin
        s2_d.t1 = '0;
        s2_d.t2 = '0;
      end
    endcase
  end

  always_comb begin
    times_o       = s2_q;
    times_o.valid = s2_valid_q;
  end

  // In every real sector both active times come from projections of the right sign.
  a_times_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && svpwm_pkg::code_ok(s2_q.code) |-> (s2_q.t1 >= 0) && (s2_q.t2 >= 0))
    else $error("active time negative in a valid sector");

endmodule

/* sv/svpwm_duty.sv */
// Duty stage: zero time, per-phase duty selection and saturation to 0 .. 1.0.
module svpwm_duty (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  svpwm_pkg::times_t  times_i,
  output svpwm_pkg::duty_t   duty_o
);

  localparam int unsigned DW = svpwm_pkg::DutyW;
  localparam int unsigned SW = svpwm_pkg::SatW;
  localparam logic signed [DW-1:0] Half = DW'(64'sd2147483648);
  localparam logic signed [DW-1:0] Full = DW'(64'sd4294967296);

  logic signed [DW-1:0] t1, t2, lo, hi, mid1, mid2;
  logic signed [DW-1:0] du, dv, dw;
  logic                 valid_q;
  svpwm_pkg::duty_t     duty_q, duty_d;

  // A duty at or below zero gives compare 0; one at or above 1.0 gives the top.
  function automatic logic [SW-1:0] sat(input logic signed [DW-1:0] d);
    logic [SW-1:0] r;
    if (d <= 0) begin
      r = '0;
    end else if (d >= Full) begin
      r = Full[SW-1:0];
    end else begin
      r = d[SW-1:0];
    end
    return r;
  endfunction

  assign t1 = DW'(times_i.t1);
  assign t2 = DW'(times_i.t2);

  // Q.32 duties: lo = T0/2, hi = T1 + T2 + T0/2, midN = TN + T0/2.
  assign lo   = Half - t1 - t2;
  assign hi   = Half + t1 + t2;
  assign mid1 = Half + t1 - t2;
  assign mid2 = Half - t1 + t2;

  always_comb begin
    case (times_i.code)
      svpwm_pkg::SgnIJ: begin
        du = hi;   dv = mid2; dw = lo;
      end
      svpwm_pkg::SgnJ: begin
        du = mid1; dv = hi;   dw = lo;
      end
      svpwm_pkg::SgnJK: begin
        du = lo;   dv = hi;   dw = mid2;
      end
      svpwm_pkg::SgnK: begin
        du = lo;   dv = mid1; dw = hi;
      end
      svpwm_pkg::SgnIK: begin
        du = mid2; dv = lo;   dw = hi;
      end
      svpwm_pkg::SgnI: begin
        du = hi;   dv = lo;   dw = mid1;
      end
      default: begin
        du = '0;   dv = '0;   dw = '0;
      end
    endcase
  end

  always_comb begin
    duty_d.valid = 1'b1;
    duty_d.code  = times_i.code;
    duty_d.du    = sat(du);
    duty_d.dv    = sat(dv);
    duty_d.dw    = sat(dw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= times_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    duty_q <= duty_d;
  end

  always_comb begin
    duty_o       = duty_q;
    duty_o.valid = valid_q;
  end

endmodule

/* sv/svpwm_scale.sv */
// Output stage: scales saturated duties by the timer top and registers the result.
module svpwm_scale (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  svpwm_pkg::duty_t               duty_i,
  input  logic [svpwm_pkg::CmpW-1:0]     top_i,
  output logic                           valid_o,
  output svpwm_pkg::out_t                out_o
);

  localparam int unsigned SW = svpwm_pkg::SatW;
  localparam int unsigned CW = svpwm_pkg::CmpW;
  localparam int unsigned PW = SW + CW;

  logic [PW-1:0]   pu, pv, pw;
  logic            valid_q;
  svpwm_pkg::out_t out_q, out_d;

  // A duty of exactly 1.0 yields top, so the upper product bits never exceed top.
  assign pu = PW'(duty_i.du) * PW'(top_i);
  assign pv = PW'(duty_i.dv) * PW'(top_i);
  assign pw = PW'(duty_i.dw) * PW'(top_i);

  always_comb begin
    out_d.compare_u = pu[32 +: CW];
    out_d.compare_v = pv[32 +: CW];
    out_d.compare_w = pw[32 +: CW];
    out_d.sector    = svpwm_pkg::sector_of(duty_i.code);
    out_d.updated   = svpwm_pkg::code_ok(duty_i.code);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= duty_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

/* sv/space_vector_pwm_duty_core.sv */
// A transaction accepted on start passes through the alpha product, projection, duty
// and scaling registers in that order and is then taken from out_o, with strobe_o high.
// Throughput: one transaction per cycle; busy is never raised.
// The result is on out_o for exactly one cycle and cannot be held off.
// Reset clears the pipeline valid bits and sets the timer top (top_q) to 1799.
module space_vector_pwm_duty_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  svpwm_pkg::in_t              in_i,
  input  logic                        cfg_we_i,
  input  logic [svpwm_pkg::CmpW-1:0]  cfg_wdata_i,
  output logic                        strobe_o,
  output svpwm_pkg::out_t             out_o
);

  logic [svpwm_pkg::CmpW-1:0] top_q;
  logic                       accept;
  svpwm_pkg::times_t          times;
  svpwm_pkg::duty_t           duty;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= svpwm_pkg::TopReset;
    end else if (cfg_we_i) begin
      top_q <= cfg_wdata_i;
    end
  end

  svpwm_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .in_i    (in_i),
    .times_o (times)
  );

  svpwm_duty u_duty (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .times_i (times),
    .duty_o  (duty)
  );

  svpwm_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .duty_i  (duty),
    .top_i   (top_q),
    .valid_o (strobe_o),
    .out_o   (out_o)
  );

  a_strobe_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept, 4))
    else $error("result strobe without a transaction four cycles earlier");

  a_no_update_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !out_o.updated |-> (out_o.compare_u == '0) && (out_o.compare_v == '0)
                                   && (out_o.compare_w == '0) && (out_o.sector == '0))
    else $error("non-updating result carries nonzero fields");

  a_update_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && out_o.updated |-> (out_o.sector != 3'd0) && (out_o.sector != 3'd7))
    else $error("updating result without a sector");

endmodule
